>>> hw/rtl/bpa_pkg.sv
`timescale 1ns / 1ps

package bpa_pkg;

   localparam int REQ_SIZE_W  = 32;
   localparam int BLOCK_ID_W  = 32;
   localparam int GRANT_W     = 6;
   localparam int OUT_ADDR_W  = 48;
   localparam int SIZE_W      = 33;
   localparam int PAD_W       = 6;
   localparam int PAD_NEED_W  = 34;
   localparam int LEFT_W      = 41;
   localparam int POOL_W      = 40;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 48;

   localparam logic [LEFT_W-1:0] POOL_RESET_BYTES = 41'd104857600;
   localparam logic [SIZE_W-1:0] ROUND_ADD        = 33'd63;
   localparam logic [SIZE_W-1:0] ALIGN_MASK       = ~33'd31;

   localparam logic [1:0] MODE_ALLOC = 2'd0;
   localparam logic [1:0] MODE_FREE  = 2'd1;
   localparam logic [1:0] MODE_GET   = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_ADDRESS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POOL_BYTES   = 2'd1;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_EXHAUSTED  = 2'd1,
      STATUS_NEG_ID     = 2'd2,
      STATUS_UNKNOWN_ID = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_CARVE_PREP,
      ST_CARVE_DONE,
      ST_CHECK
   } state_type;

   typedef struct packed {
      logic [1:0]                   mode;
      logic [REQ_SIZE_W-1:0]        request_size;
      logic signed [BLOCK_ID_W-1:0] block_id;
   } req_type;

   typedef struct packed {
      status_type              status;
      logic [GRANT_W-1:0]      granted_id;
      logic [OUT_ADDR_W-1:0]   block_address;
   } rsp_type;

   typedef struct packed {
      logic                  wr_base;
      logic                  wr_pool;
      logic [CSR_DATA_W-1:0] data;
   } cfg_write_type;

   typedef struct packed {
      logic rd_en;
      logic wr_use;
      logic wr_full;
      logic use_val;
   } mem_ctl_type;

endpackage

>>> hw/rtl/bpa_entry_mem.sv
`timescale 1ns / 1ps

module bpa_entry_mem
   import bpa_pkg::*;
#(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 48,
   localparam int IDX_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  mem_ctl_type       ctl,
   input  logic [IDX_W-1:0]  rd_idx,
   input  logic [IDX_W-1:0]  wr_idx,
   input  logic [SIZE_W-1:0] wr_size,
   input  logic [ADDR_W-1:0] wr_start,
   output logic              rd_use,
   output logic [SIZE_W-1:0] rd_size,
   output logic [ADDR_W-1:0] rd_start
);

   logic              use_mem   [DEPTH];
   logic [SIZE_W-1:0] size_mem  [DEPTH];
   logic [ADDR_W-1:0] start_mem [DEPTH];

   logic              rd_use_ff;
   logic [SIZE_W-1:0] rd_size_ff;
   logic [ADDR_W-1:0] rd_start_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_use) begin
         use_mem[wr_idx] <= ctl.use_val;
      end
      if (ctl.wr_full) begin
         size_mem[wr_idx]  <= wr_size;
         start_mem[wr_idx] <= wr_start;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_use_ff   <= use_mem[rd_idx];
         rd_size_ff  <= size_mem[rd_idx];
         rd_start_ff <= start_mem[rd_idx];
      end
   end

   assign rd_use   = rd_use_ff;
   assign rd_size  = rd_size_ff;
   assign rd_start = rd_start_ff;

endmodule

>>> hw/rtl/bpa_core.sv
`timescale 1ns / 1ps

module bpa_core
   import bpa_pkg::*;
#(
   parameter int MAX_BLOCKS   = 64,
   parameter int ADDRESS_BITS = 48,
   localparam int IDX_W = $clog2(MAX_BLOCKS),
   localparam int NBN_W = $clog2(MAX_BLOCKS + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  req_type                 req,
   output logic                    busy,
   input  cfg_write_type           cfg,
   output mem_ctl_type             mem_ctl,
   output logic [IDX_W-1:0]        rd_idx,
   output logic [IDX_W-1:0]        wr_idx,
   output logic [SIZE_W-1:0]       wr_size,
   output logic [ADDRESS_BITS-1:0] wr_start,
   input  logic                    rd_use,
   input  logic [SIZE_W-1:0]       rd_size,
   input  logic [ADDRESS_BITS-1:0] rd_start,
   output logic                    rsp_valid,
   output rsp_type                 rsp
);

   localparam int ADDR_W = ADDRESS_BITS;

   state_type             state_ff, state_in;
   logic [NBN_W-1:0]      nbn_ff, nbn_in;
   logic [ADDR_W-1:0]     bump_ff, bump_in;
   logic [LEFT_W-1:0]     left_ff, left_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  issued_ff, issued_in;

   logic [1:0]            mode_ff, mode_in;
   logic [SIZE_W-1:0]     need_ff, need_in;
   logic [BLOCK_ID_W-1:0] id_ff, id_in;
   logic [NBN_W-1:0]      scan_idx_ff, scan_idx_in;
   logic [IDX_W-1:0]      chk_idx_ff, chk_idx_in;
   logic [PAD_NEED_W-1:0] pad_need_ff, pad_need_in;
   logic [ADDR_W-1:0]     start_ff, start_in;
   rsp_type               rsp_ff, rsp_in;

   logic [PAD_W-1:0]      pad;
   logic                  hit;

   function automatic rsp_type make_rsp(status_type st, logic [GRANT_W-1:0] gid,
                                        logic [OUT_ADDR_W-1:0] addr);
      rsp_type r;
      r.status        = st;
      r.granted_id    = gid;
      r.block_address = addr;
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         nbn_ff       <= '0;
         bump_ff      <= '0;
         left_ff      <= POOL_RESET_BYTES;
         rsp_valid_ff <= 1'b0;
         issued_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nbn_ff       <= nbn_in;
         bump_ff      <= bump_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
         issued_ff    <= issued_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      need_ff     <= need_in;
      id_ff       <= id_in;
      scan_idx_ff <= scan_idx_in;
      chk_idx_ff  <= chk_idx_in;
      pad_need_ff <= pad_need_in;
      start_ff    <= start_in;
      rsp_ff      <= rsp_in;
   end

   assign pad = -bump_ff[PAD_W-1:0];
   assign hit = issued_ff && !rd_use && (rd_size >= need_ff);

   always_comb begin
      state_in     = state_ff;
      nbn_in       = nbn_ff;
      bump_in      = bump_ff;
      left_in      = left_ff;
      rsp_valid_in = 1'b0;
      issued_in    = issued_ff;
      mode_in      = mode_ff;
      need_in      = need_ff;
      id_in        = id_ff;
      scan_idx_in  = scan_idx_ff;
      chk_idx_in   = chk_idx_ff;
      pad_need_in  = pad_need_ff;
      start_in     = start_ff;
      rsp_in       = rsp_ff;
      mem_ctl      = '0;
      rd_idx       = '0;
      wr_idx       = '0;
      wr_size      = need_ff;
      wr_start     = start_ff;

      // reload the bump pointer and space left until the first block exists
      if (cfg.wr_base && (nbn_ff == '0)) begin
         bump_in = ADDR_W'(cfg.data);
      end
      if (cfg.wr_pool && (nbn_ff == '0)) begin
         left_in = LEFT_W'(cfg.data[POOL_W-1:0]);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mode_in  = req.mode;
               need_in  = (SIZE_W'(req.request_size) + ROUND_ADD) & ALIGN_MASK;
               id_in    = req.block_id;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (mode_ff) inside
               MODE_ALLOC: begin
                  scan_idx_in = '0;
                  issued_in   = 1'b0;
                  state_in    = ST_SCAN;
               end
               MODE_FREE, MODE_GET: begin
                  if (id_ff[BLOCK_ID_W-1]) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = make_rsp(STATUS_NEG_ID, '0, '0);
                     state_in     = ST_IDLE;
                  end else if (id_ff >= BLOCK_ID_W'(nbn_ff)) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = make_rsp(STATUS_UNKNOWN_ID, '0, '0);
                     state_in     = ST_IDLE;
                  end else begin
                     mem_ctl.rd_en = 1'b1;
                     rd_idx        = id_ff[IDX_W-1:0];
                     state_in      = ST_CHECK;
                  end
               end
               default: begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = make_rsp(STATUS_OK, '0, '0);
                  state_in     = ST_IDLE;
               end
            endcase
         end
         ST_SCAN: begin
            if (hit) begin
               mem_ctl.wr_use  = 1'b1;
               mem_ctl.use_val = 1'b1;
               wr_idx          = chk_idx_ff;
               issued_in       = 1'b0;
               rsp_valid_in    = 1'b1;
               rsp_in          = make_rsp(STATUS_OK, GRANT_W'(chk_idx_ff),
                                          OUT_ADDR_W'(rd_start));
               state_in        = ST_IDLE;
            end else if (scan_idx_ff < nbn_ff) begin
               mem_ctl.rd_en = 1'b1;
               rd_idx        = scan_idx_ff[IDX_W-1:0];
               chk_idx_in    = scan_idx_ff[IDX_W-1:0];
               issued_in     = 1'b1;
               scan_idx_in   = NBN_W'(scan_idx_ff + 1'b1);
            end else begin
               issued_in = 1'b0;
               state_in  = ST_CARVE_PREP;
            end
         end
         ST_CARVE_PREP: begin
            pad_need_in = PAD_NEED_W'(need_ff) + PAD_NEED_W'(pad);
            start_in    = bump_ff + ADDR_W'(pad);
            state_in    = ST_CARVE_DONE;
         end
         ST_CARVE_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            if ((nbn_ff >= NBN_W'(MAX_BLOCKS)) || (left_ff <= LEFT_W'(pad_need_ff))) begin
               rsp_in = make_rsp(STATUS_EXHAUSTED, '0, '0);
            end else begin
               mem_ctl.wr_use  = 1'b1;
               mem_ctl.wr_full = 1'b1;
               mem_ctl.use_val = 1'b1;
               wr_idx          = nbn_ff[IDX_W-1:0];
               nbn_in          = NBN_W'(nbn_ff + 1'b1);
               bump_in         = start_ff + ADDR_W'(need_ff);
               left_in         = left_ff - LEFT_W'(pad_need_ff);
               rsp_in          = make_rsp(STATUS_OK, GRANT_W'(nbn_ff),
                                          OUT_ADDR_W'(start_ff));
            end
         end
         ST_CHECK: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            if (!rd_use) begin
               rsp_in = make_rsp(STATUS_UNKNOWN_ID, '0, '0);
            end else if (mode_ff == MODE_FREE) begin
               mem_ctl.wr_use  = 1'b1;
               mem_ctl.use_val = 1'b0;
               wr_idx          = id_ff[IDX_W-1:0];
               rsp_in          = make_rsp(STATUS_OK, '0, '0);
            end else begin
               rsp_in = make_rsp(STATUS_OK, '0, OUT_ADDR_W'(rd_start));
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

`ifndef SYNTH
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for more than one cycle");

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a start transfer");

   a_nbn_bound: assert property (@(posedge clock) disable iff (reset)
      nbn_ff <= NBN_W'(MAX_BLOCKS))
      else $error("block counter past pool limit");

   a_nbn_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(nbn_ff) |-> (nbn_ff == NBN_W'($past(nbn_ff) + 1'b1)))
      else $error("block counter moved by other than one");

   a_err_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status != STATUS_OK)) |->
         ((rsp_ff.granted_id == '0) && (rsp_ff.block_address == '0)))
      else $error("error result carries nonzero fields");
`endif

endmodule

>>> hw/rtl/block_pool_allocator.sv
`timescale 1ns / 1ps

// Block pool allocator: allocate, free and address lookup over a bump-carved pool.
// Request channel: an item transfers at a rising edge with start high and busy low;
// busy stays high until the result is issued, and a new start is taken in the
// cycle the result is shown.
// Result channel: rsp_valid is high for exactly one cycle with rsp_data; the
// receiver cannot stall it and must take it in that cycle.
// CSR channel: csr_index 0 writes the pool base address, 1 writes the pool byte
// count; ready while the block is idle and start is low. A write reloads the bump
// pointer or the space left only before the first block is carved.
// Flow: a negative id, an id never carved and the unused mode return the result
// from the decode state; free and get of a carved id first read the entry and
// answer from the check state. Allocate walks the entry table one entry per cycle
// through the single registered read port of the entry memory and returns on the
// first-fit hit; with no hit it carves a new block (or fails) in the carve prep
// and carve done states.
// Reset: synchronous; clears all ids, bump pointer to 0, space left to
// 104857600 bytes. No clearing pass is needed.

module block_pool_allocator
   import bpa_pkg::*;
#(
   parameter int MAX_BLOCKS   = 64,
   parameter int ADDRESS_BITS = 48
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_data,
   output logic                   rsp_valid,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int IDX_W = $clog2(MAX_BLOCKS);

   cfg_write_type           cfg;
   mem_ctl_type             mem_ctl;
   logic [IDX_W-1:0]        rd_idx;
   logic [IDX_W-1:0]        wr_idx;
   logic [SIZE_W-1:0]       wr_size;
   logic [ADDRESS_BITS-1:0] wr_start;
   logic                    rd_use;
   logic [SIZE_W-1:0]       rd_size;
   logic [ADDRESS_BITS-1:0] rd_start;

   assign csr_ready = !busy && !start;

   always_comb begin
      cfg      = '0;
      cfg.data = csr_data;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BASE_ADDRESS: cfg.wr_base = 1'b1;
            CSR_POOL_BYTES:   cfg.wr_pool = 1'b1;
            default: begin
            end
         endcase
      end
   end

   bpa_core #(
      .MAX_BLOCKS   (MAX_BLOCKS),
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req_data),
      .busy      (busy),
      .cfg       (cfg),
      .mem_ctl   (mem_ctl),
      .rd_idx    (rd_idx),
      .wr_idx    (wr_idx),
      .wr_size   (wr_size),
      .wr_start  (wr_start),
      .rd_use    (rd_use),
      .rd_size   (rd_size),
      .rd_start  (rd_start),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

   bpa_entry_mem #(
      .DEPTH  (MAX_BLOCKS),
      .ADDR_W (ADDRESS_BITS)
   ) u_mem (
      .clock    (clock),
      .ctl      (mem_ctl),
      .rd_idx   (rd_idx),
      .wr_idx   (wr_idx),
      .wr_size  (wr_size),
      .wr_start (wr_start),
      .rd_use   (rd_use),
      .rd_size  (rd_size),
      .rd_start (rd_start)
   );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import bpa_pkg::*;

   localparam int          ID_SLOTS     = 64;
   localparam int unsigned CYCLE_LIMIT  = 1500000;
   localparam logic [1:0]  MODE_UNUSED  = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   req_type                req_data = '0;
   logic                   rsp_valid;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   block_pool_allocator u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // pool state as the block should hold it
   bit          blk_used [ID_SLOTS];
   bit          blk_made [ID_SLOTS];
   logic [32:0] blk_bytes [ID_SLOTS];
   logic [47:0] blk_addr [ID_SLOTS];
   logic [6:0]  next_id;
   logic [47:0] bump_ptr;
   logic [40:0] space_left;

   req_type     op_feed [$];
   rsp_type     expected_rsp [$];
   int unsigned ops_sent = 0;
   int unsigned ops_taken = 0;
   int unsigned pause_left = 0;
   int unsigned fail_count = 0;
   int unsigned cycle_count = 0;
   bit          steady_feed = 1'b0;

   function automatic rsp_type predict_pool_op(input req_type r);
      rsp_type     o;
      logic [32:0] need;
      logic [5:0]  pad;
      logic [47:0] at;
      logic [31:0] rid;
      bit          hit;
      o = '0;
      o.status = STATUS_OK;
      rid = r.block_id;
      if (r.mode == MODE_ALLOC) begin
         need = (({1'b0, r.request_size} + 33'd31) & ~33'd31) + 33'd32;
         hit = 1'b0;
         for (int k = 0; k < ID_SLOTS; k++) begin
            if (!hit && blk_made[k] && !blk_used[k] && blk_bytes[k] >= need) begin
               hit = 1'b1;
               blk_used[k] = 1'b1;
               o.granted_id = 6'(k);
               o.block_address = blk_addr[k];
            end
         end
         if (!hit) begin
            pad = 6'd0 - bump_ptr[5:0];
            if (next_id >= 7'(ID_SLOTS) || space_left <= 41'(need) + 41'(pad)) begin
               o.status = STATUS_EXHAUSTED;
            end else begin
               at = bump_ptr + 48'(pad);
               blk_made[next_id[5:0]] = 1'b1;
               blk_used[next_id[5:0]] = 1'b1;
               blk_bytes[next_id[5:0]] = need;
               blk_addr[next_id[5:0]] = at;
               o.granted_id = next_id[5:0];
               o.block_address = at;
               next_id = next_id + 7'd1;
               bump_ptr = at + 48'(need);
               space_left = space_left - 41'(need) - 41'(pad);
            end
         end
      end else if (r.mode == MODE_FREE || r.mode == MODE_GET) begin
         if (rid[31]) begin
            o.status = STATUS_NEG_ID;
         end else if (rid >= 32'(ID_SLOTS) || !blk_made[rid[5:0]] || !blk_used[rid[5:0]]) begin
            o.status = STATUS_UNKNOWN_ID;
         end else if (r.mode == MODE_FREE) begin
            blk_used[rid[5:0]] = 1'b0;
         end else begin
            o.block_address = blk_addr[rid[5:0]];
         end
      end
      return o;
   endfunction

   function automatic void apply_reg(input logic [CSR_INDEX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] val);
      if (idx == CSR_BASE_ADDRESS) begin
         if (next_id == 7'd0)
            bump_ptr = val;
      end else if (idx == CSR_POOL_BYTES) begin
         if (next_id == 7'd0)
            space_left = {1'b0, val[39:0]};
      end
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (steady_feed)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 80);
   endfunction

   task automatic queue_op(input logic [1:0] m, input logic [31:0] sz, input logic [31:0] id);
      req_type r;
      r.mode = m;
      r.request_size = sz;
      r.block_id = id;
      op_feed.push_back(r);
      ops_sent++;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      apply_reg(idx, val);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (ops_sent != ops_taken || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   always @(posedge clock) begin : feed_proc
      int unsigned pause;
      bit          took;
      took = 1'b0;
      if (reset) begin
         start <= 1'b0;
         pause_left <= 0;
      end else begin
         if (start && !busy) begin
            expected_rsp.push_back(predict_pool_op(req_data));
            ops_taken++;
            took = 1'b1;
         end
         if (!start || took) begin
            pause = took ? pick_gap() : pause_left;
            if (pause > 0) begin
               pause_left <= pause - 1;
               start <= 1'b0;
            end else if (op_feed.size() != 0) begin
               req_data <= op_feed.pop_front();
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_proc
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_rsp.size() == 0) begin
            $error("result with nothing outstanding: status %0d, id %0d, address %h",
                   rsp_data.status, rsp_data.granted_id, rsp_data.block_address);
            fail_count++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.granted_id !== want.granted_id) begin
               $error("granted_id: expected %0d, got %0d", want.granted_id, rsp_data.granted_id);
               fail_count++;
            end
            if (rsp_data.block_address !== want.block_address) begin
               $error("block_address: expected %h, got %h",
                      want.block_address, rsp_data.block_address);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int unsigned   pick;
      logic [1:0]    m;
      logic [31:0]   sz;
      logic [31:0]   id;
      logic [47:0]   word;

      for (int k = 0; k < ID_SLOTS; k++) begin
         blk_used[k] = 1'b0;
         blk_made[k] = 1'b0;
         blk_bytes[k] = '0;
         blk_addr[k] = '0;
      end
      next_id = '0;
      bump_ptr = '0;
      space_left = POOL_RESET_BYTES;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // nothing created yet: bad ids, unused mode
      queue_op(MODE_GET, 32'h0, 32'h8000_0000);
      queue_op(MODE_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_op(MODE_FREE, 32'h0, 32'd0);
      queue_op(MODE_GET, 32'h0, 32'h7FFF_FFFF);
      queue_op(MODE_GET, 32'h0, 32'd64);
      queue_op(MODE_UNUSED, 32'hA5A5_5A5A, 32'h5A5A_A5A5);
      wait_idle();

      write_reg(CSR_BASE_ADDRESS, 48'hFFFF_FFFF_FFFF);
      write_reg(CSR_SPARE_2, 48'h1234_5678_9ABC);
      write_reg(CSR_SPARE_3, 48'hFFFF_FFFF_FFFF);
      write_reg(CSR_POOL_BYTES, 48'h0);
      queue_op(MODE_ALLOC, 32'd0, 32'd0);
      wait_idle();

      // padding plus block size equal to the space left must fail
      write_reg(CSR_BASE_ADDRESS, 48'hFFFF_FFFF_FF9C);
      write_reg(CSR_POOL_BYTES, 48'hAB00_0000_0064);
      queue_op(MODE_ALLOC, 32'd32, 32'd0);
      wait_idle();

      // carve across the address wrap, reuse, double free
      write_reg(CSR_POOL_BYTES, 48'h0003_0000_0000);
      queue_op(MODE_ALLOC, 32'd0, 32'd0);
      queue_op(MODE_ALLOC, 32'd1, 32'd0);
      queue_op(MODE_ALLOC, 32'hFFFF_FFFF, 32'd0);
      queue_op(MODE_ALLOC, 32'd33, 32'd0);
      queue_op(MODE_GET, 32'd0, 32'd1);
      queue_op(MODE_FREE, 32'd0, 32'd1);
      queue_op(MODE_FREE, 32'd0, 32'd1);
      queue_op(MODE_ALLOC, 32'd20, 32'd0);
      queue_op(MODE_GET, 32'd0, 32'd2);
      queue_op(MODE_FREE, 32'd0, 32'd0);
      queue_op(MODE_GET, 32'd0, 32'd0);
      wait_idle();

      // register only from here on
      write_reg(CSR_POOL_BYTES, 48'hFFFF_FFFF_FFFF);
      write_reg(CSR_BASE_ADDRESS, 48'h0);

      for (int phase = 0; phase < 4; phase++) begin
         steady_feed = (phase == 1);
         repeat (470) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
               m = MODE_ALLOC;
            else if (pick < 70)
               m = MODE_FREE;
            else if (pick < 94)
               m = MODE_GET;
            else
               m = MODE_UNUSED;
            pick = $urandom_range(0, 99);
            if (pick < 80)
               sz = $urandom_range(0, 1200);
            else if (pick < 95)
               sz = $urandom_range(0, 70000);
            else
               sz = $urandom();
            pick = $urandom_range(0, 99);
            if (pick < 82)
               id = $urandom_range(0, ID_SLOTS - 1);
            else if (pick < 88)
               id = $urandom_range(ID_SLOTS, 200);
            else
               id = $urandom();
            queue_op(m, sz, id);
         end
         wait_idle();
         word = 48'({$urandom(), $urandom()});
         write_reg(CSR_BASE_ADDRESS, word);
         word = (phase == 2) ? 48'h0 : 48'({$urandom(), $urandom()});
         write_reg(CSR_POOL_BYTES, word);
      end

      wait_idle();
      repeat (80) @(posedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
